// ----- rtl/rotb_pkg.sv -----
package rotb_pkg;

  localparam int NUM_TIMERS = 2;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [7:0] OFF_IRQ_EN     = 8'h00;
  localparam logic [7:0] OFF_IRQ_STATUS = 8'h04;

  localparam logic [3:0] TREG_CTL  = 4'h0;
  localparam logic [3:0] TREG_INTV = 4'h4;
  localparam logic [3:0] TREG_CUR  = 4'h8;

  localparam int CTL_ONESHOT_BIT = 7;
  localparam int CTL_FAST_BIT    = 2;
  localparam int CTL_RELOAD_BIT  = 1;
  localparam int CTL_ENABLE_BIT  = 0;
  localparam int CTL_DIV_LSB     = 4;
  localparam logic [7:0] CTL_STORE_MASK = 8'hF5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  reg_offset;
    logic [31:0] write_data;
    logic        slow_tick;
    logic        fast_tick;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_line;
  } rsp_t;

  typedef struct packed {
    logic        tick;
    logic        slow;
    logic        fast;
    logic        wr_ctl;
    logic        wr_intv;
    logic        wr_cur;
    logic [31:0] data;
  } tmr_cmd_t;

endpackage

// ----- rtl/rotb_timer.sv -----
module rotb_timer
  import rotb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  tmr_cmd_t    cmd,
  output logic [7:0]  ctl,
  output logic [31:0] intv,
  output logic [31:0] cur,
  output logic        expire
);

  logic [7:0]  ctl_next;
  logic [31:0] intv_next;
  logic [31:0] cur_next;
  logic [6:0]  pcount;
  logic [6:0]  pcount_next;
  logic [6:0]  limit;
  logic [2:0]  div;
  logic        ticked;

  always_comb begin
    ctl_next    = ctl;
    intv_next   = intv;
    cur_next    = cur;
    pcount_next = pcount;
    expire      = 1'b0;
    div         = ctl[CTL_DIV_LSB +: 3];
    limit       = ~(7'h7F << div);
    ticked      = ctl[CTL_FAST_BIT] ? cmd.fast : cmd.slow;

    if (cmd.tick && ctl[CTL_ENABLE_BIT] && ticked) begin
      if (pcount < limit) begin
        pcount_next = pcount + 7'd1;
      end else begin
        pcount_next = '0;
        if (cur > 32'd1) begin
          cur_next = cur - 32'd1;
        end else begin
          expire = 1'b1;
          if (ctl[CTL_ONESHOT_BIT]) begin
            cur_next                 = '0;
            ctl_next[CTL_ENABLE_BIT] = 1'b0;
          end else begin
            cur_next = intv;
          end
        end
      end
    end

    if (cmd.wr_ctl) begin
      ctl_next = cmd.data[7:0] & CTL_STORE_MASK;
      if (cmd.data[CTL_RELOAD_BIT]) begin
        cur_next    = intv;
        pcount_next = '0;
      end
    end
    if (cmd.wr_intv) begin
      intv_next = cmd.data;
    end
    if (cmd.wr_cur) begin
      cur_next = cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl    <= '0;
      intv   <= '0;
      cur    <= '0;
      pcount <= '0;
    end else begin
      ctl    <= ctl_next;
      intv   <= intv_next;
      cur    <= cur_next;
      pcount <= pcount_next;
    end
  end

  a_reload_copies_interval: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_ctl && cmd.data[CTL_RELOAD_BIT] |=> cur == $past(intv))
    else $error("reload did not copy interval");

  a_expire_only_enabled: assert property (@(posedge clk) disable iff (rst)
    expire |-> ctl[CTL_ENABLE_BIT] && cmd.tick)
    else $error("expiry on disabled timer");

endmodule

// ----- rtl/reload_oneshot_timer_bank.sv -----
// Each accepted item's result is registered into the output register.
// Throughput: one item per cycle while the input is not stalled; every timer updates in parallel in one step.
// The input stalls only while a result waits in the output register and is stalled.
// Reset (synchronous, active high) clears IRQ enable and status, all timer
// control, interval, current value and prescale registers, and the output valid.
module reload_oneshot_timer_bank
  import rotb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic                  acc;
  logic                  aligned;
  logic [NUM_TIMERS-1:0] irq_en;
  logic [NUM_TIMERS-1:0] irq_en_next;
  logic [NUM_TIMERS-1:0] irq_pend;
  logic [NUM_TIMERS-1:0] irq_pend_next;
  logic [NUM_TIMERS-1:0] t_expire;
  logic [NUM_TIMERS-1:0] t_hit;
  logic [7:0]            t_ctl  [NUM_TIMERS];
  logic [31:0]           t_intv [NUM_TIMERS];
  logic [31:0]           t_cur  [NUM_TIMERS];
  tmr_cmd_t              t_cmd  [NUM_TIMERS];
  logic [31:0]           rd_next;
  logic                  is_wr;
  logic                  is_rd;

  assign req_stall = rsp_valid && rsp_stall;
  assign acc       = req_valid && !req_stall;
  assign aligned   = (req.reg_offset[1:0] == 2'b00);
  assign is_wr     = acc && (req.req_type == REQ_WRITE);
  assign is_rd     = (req.req_type == REQ_READ);

  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      t_hit[i]         = aligned && (req.reg_offset[7:4] == 4'(i + 1));
      t_cmd[i].tick    = acc && (req.req_type == REQ_TICK);
      t_cmd[i].slow    = req.slow_tick;
      t_cmd[i].fast    = req.fast_tick;
      t_cmd[i].wr_ctl  = is_wr && t_hit[i] && (req.reg_offset[3:0] == TREG_CTL);
      t_cmd[i].wr_intv = is_wr && t_hit[i] && (req.reg_offset[3:0] == TREG_INTV);
      t_cmd[i].wr_cur  = is_wr && t_hit[i] && (req.reg_offset[3:0] == TREG_CUR);
      t_cmd[i].data    = req.write_data;
    end
  end

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_timer
    rotb_timer u_timer (
      .clk    (clk),
      .rst    (rst),
      .cmd    (t_cmd[g]),
      .ctl    (t_ctl[g]),
      .intv   (t_intv[g]),
      .cur    (t_cur[g]),
      .expire (t_expire[g])
    );
  end

  always_comb begin
    irq_en_next   = irq_en;
    irq_pend_next = irq_pend | t_expire;
    if (is_wr && req.reg_offset == OFF_IRQ_EN) begin
      irq_en_next = req.write_data[NUM_TIMERS-1:0];
    end
    if (is_wr && req.reg_offset == OFF_IRQ_STATUS) begin
      irq_pend_next = irq_pend & ~req.write_data[NUM_TIMERS-1:0];
    end

    rd_next = '0;
    if (is_rd) begin
      if (req.reg_offset == OFF_IRQ_EN) begin
        rd_next = 32'(irq_en);
      end else if (req.reg_offset == OFF_IRQ_STATUS) begin
        rd_next = 32'(irq_pend);
      end
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (t_hit[i]) begin
          case (req.reg_offset[3:0])
            TREG_CTL:  rd_next = rd_next | 32'(t_ctl[i]);
            TREG_INTV: rd_next = rd_next | t_intv[i];
            TREG_CUR:  rd_next = rd_next | t_cur[i];
            default:   rd_next = rd_next;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_en    <= '0;
      irq_pend  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (acc) begin
        irq_en   <= irq_en_next;
        irq_pend <= irq_pend_next;
      end
      if (acc) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp.read_data <= rd_next;
      rsp.irq_line  <= |(irq_pend_next & irq_en_next);
    end
  end

  a_irq_line_matches: assert property (@(posedge clk) disable iff (rst)
    acc |=> rsp_valid && (rsp.irq_line == |(irq_pend & irq_en)))
    else $error("irq line disagrees with status and enable");

  a_status_clear: assert property (@(posedge clk) disable iff (rst)
    is_wr && req.reg_offset == OFF_IRQ_STATUS && (&req.write_data[NUM_TIMERS-1:0])
    |=> irq_pend == '0)
    else $error("status not cleared by write");

  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    acc && !is_rd |=> rsp.read_data == '0)
    else $error("non-read item returned data");

endmodule
